// ----- src/dpf_pkg.sv -----
// Shared types, framing characters and helpers for the debug packet framer.
package dpf_pkg;

  localparam int unsigned NumSlots = 6;

  localparam logic [7:0] ChAck   = 8'h2B;
  localparam logic [7:0] ChStart = 8'h24;
  localparam logic [7:0] ChHash  = 8'h23;

  typedef enum logic [2:0] {
    SlotAck     = 3'd0,
    SlotStart   = 3'd1,
    SlotPayload = 3'd2,
    SlotHash    = 3'd3,
    SlotHi      = 3'd4,
    SlotLo      = 3'd5
  } dpf_slot_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       empty_packet;
  } dpf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
  } dpf_out_t;

  typedef struct packed {
    logic     valid;
    dpf_out_t data;
  } dpf_emit_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + wide;
    end else begin
      hex_digit = 8'h57 + wide;
    end
  endfunction

endpackage

// ----- src/dpf_frame_stage.sv -----
// Request register: expands one request into its framed bytes and issues them.
module dpf_frame_stage
  import dpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dpf_in_t   in_req_i,
  input  logic      take_i,
  output dpf_emit_t emit_o
);

  logic                no_ack_q;
  logic [7:0]          sum_q, sum_d;
  logic [NumSlots-1:0] mask_q, mask_d;
  logic [7:0]          byte_q;
  logic [7:0]          chk_q, chk_d;

  logic                in_acc;
  logic                first_eff, last_eff;
  logic [7:0]          sum_base;
  logic [NumSlots-1:0] mask_new;
  logic [NumSlots-1:0] lowest, rest;
  logic                issue;
  logic [7:0]          sel_byte;

  assign lowest = mask_q & (~mask_q + {{(NumSlots-1){1'b0}}, 1'b1});
  assign rest   = mask_q & ~lowest;
  assign issue  = (mask_q != '0) && take_i;

  assign in_stall_o = !((mask_q == '0) || (issue && (rest == '0)));
  assign in_acc     = in_valid_i && !in_stall_o;

  assign first_eff = in_req_i.first_of_packet || in_req_i.empty_packet;
  assign last_eff  = in_req_i.last_of_packet || in_req_i.empty_packet;
  assign sum_base  = first_eff ? 8'h00 : sum_q;
  assign chk_d     = in_req_i.empty_packet ? sum_base : sum_base + in_req_i.payload_byte;
  assign sum_d     = last_eff ? 8'h00 : chk_d;

  always_comb begin
    mask_new              = '0;
    mask_new[SlotAck]     = first_eff && !no_ack_q;
    mask_new[SlotStart]   = first_eff;
    mask_new[SlotPayload] = !in_req_i.empty_packet;
    mask_new[SlotHash]    = last_eff;
    mask_new[SlotHi]      = last_eff;
    mask_new[SlotLo]      = last_eff;
  end

  always_comb begin
    mask_d = mask_q;
    if (issue) begin
      mask_d = rest;
    end
    if (in_acc) begin
      mask_d = mask_new;
    end
  end

  always_comb begin
    sel_byte = 8'h00;
    for (int i = 0; i < NumSlots; i++) begin
      if (lowest[i]) begin
        case (dpf_slot_e'(i[2:0]))
          SlotAck:     sel_byte = ChAck;
          SlotStart:   sel_byte = ChStart;
          SlotPayload: sel_byte = byte_q;
          SlotHash:    sel_byte = ChHash;
          SlotHi:      sel_byte = hex_digit(chk_q[7:4]);
          SlotLo:      sel_byte = hex_digit(chk_q[3:0]);
          default:     sel_byte = 8'h00;
        endcase
      end
    end
  end

  assign emit_o.valid             = mask_q != '0;
  assign emit_o.data.out_byte     = sel_byte;
  assign emit_o.data.end_of_frame = rest == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_ack_q <= 1'b0;
      sum_q    <= 8'h00;
      mask_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        no_ack_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        sum_q <= sum_d;
      end
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_req_i.payload_byte;
      chk_q  <= chk_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ((mask_q == '0) || (issue && $onehot(mask_q))))
    else $error("request accepted over pending bytes");

  a_sum_cleared_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_eff) |=> (sum_q == 8'h00))
    else $error("running sum not cleared after last request");

  a_hold_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mask_q != '0) && !take_i) |=> $stable(mask_q))
    else $error("pending bytes changed while output blocked");
`endif

endmodule

// ----- src/dpf_out_reg.sv -----
// Output register: holds one framed byte until the downstream side takes it.
module dpf_out_reg
  import dpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dpf_emit_t emit_i,
  output logic      take_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output dpf_out_t  out_req_o
);

  logic     valid_q, valid_d;
  dpf_out_t data_q;

  assign take_o  = !valid_q || !out_stall_i;
  assign valid_d = take_o ? emit_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit_i.valid) begin
      data_q <= emit_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_req_o   = data_q;

`ifndef NO_ASSERTIONS
  a_stalled_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_stall_i) |=> (valid_q && $stable(data_q)))
    else $error("stalled output byte lost or changed");
`endif

endmodule

// ----- src/debug_packet_framer_unit.sv -----
// Top level of the debug packet framer.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_stall_o   | dpf_in_t  in_req_i
//  out     | output    | out_valid_o / out_stall_i | dpf_out_t out_req_o
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (no_ack_mode)
//
// A request produces one byte mid-packet and up to 6 bytes for a single-byte packet;
// the request register issues one byte per cycle while the output register takes it.
// The next request is taken in the cycle its predecessor's last byte moves out.
// The output register follows the request register; out stall backs up into in_stall_o.
// Reset clears the running sum, no_ack_mode and both valid stages.
module debug_packet_framer_unit
  import dpf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  dpf_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output dpf_out_t out_req_o
);

  dpf_emit_t emit;
  logic      take;

  dpf_frame_stage u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .take_i      (take),
    .emit_o      (emit)
  );

  dpf_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .emit_i      (emit),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

// ----- bench/dpf_checker.sv -----
// Checker that watches the framer's channels, predicts every framed byte and compares.
module dpf_checker
  import dpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  dpf_in_t     in_req_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  dpf_out_t    out_req_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  dpf_out_t   framed_q[$];
  logic       no_ack_q;
  logic [7:0] byte_sum;

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      return 8'h30 + wide;
    end
    return 8'h61 + wide - 8'd10;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    dpf_out_t e;
    e.out_byte     = b;
    e.end_of_frame = 1'b0;
    framed_q.push_back(e);
  endfunction

  task automatic frame_request(input dpf_in_t r);
    logic opens;
    logic closes;
    opens  = r.first_of_packet | r.empty_packet;
    closes = r.last_of_packet | r.empty_packet;
    if (opens) begin
      byte_sum = 8'h00;
      if (!no_ack_q) begin
        push_byte(ChAck);
      end
      push_byte(ChStart);
    end
    if (!r.empty_packet) begin
      push_byte(r.payload_byte);
      byte_sum = byte_sum + r.payload_byte;
    end
    if (closes) begin
      push_byte(ChHash);
      push_byte(ascii_hex(byte_sum[7:4]));
      push_byte(ascii_hex(byte_sum[3:0]));
      byte_sum = 8'h00;
    end
    framed_q[framed_q.size() - 1].end_of_frame = 1'b1;
  endtask

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dpf_out_t want;
    if (!rst_ni) begin
      framed_q.delete();
      no_ack_q     = 1'b0;
      byte_sum     = 8'h00;
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        no_ack_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        frame_request(in_req_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (framed_q.size() == 0) begin
          report($sformatf("unexpected byte %h eof %b",
                           out_req_i.out_byte, out_req_i.end_of_frame));
        end else begin
          want = framed_q.pop_front();
          checked_o++;
          if (out_req_i.out_byte !== want.out_byte) begin
            report($sformatf("out_byte %h, want %h", out_req_i.out_byte, want.out_byte));
          end
          if (out_req_i.end_of_frame !== want.end_of_frame) begin
            report($sformatf("end_of_frame %b, want %b on byte %h",
                             out_req_i.end_of_frame, want.end_of_frame, want.out_byte));
          end
        end
      end
      pending_o = framed_q.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
// Testbench top: drives requests, config writes and output stalls, and gives the verdict.
module tb_top;
  import dpf_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned PhaseItems  = 50;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid  = 1'b0;
  logic        out_stall = 1'b0;
  dpf_in_t     in_req    = '0;
  logic        in_stall;
  logic        out_valid;
  dpf_out_t    out_req;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned items_sent   = 0;
  int unsigned packets_sent = 0;
  int unsigned idle_cycles  = 0;
  bit          calm         = 1'b0;

  debug_packet_framer_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  dpf_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_req_i   (out_req),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("watchdog: no handshake for %0d cycles, %0d bytes outstanding",
               StallLimit, pending);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int unsigned draw_wait();
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  initial begin
    int unsigned n;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      n = draw_wait();
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!(out_valid && !out_stall));
      @(negedge clk_i);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                           input logic empty);
    int unsigned gap;
    dpf_in_t     r;
    r.payload_byte    = b;
    r.first_of_packet = first;
    r.last_of_packet  = last;
    r.empty_packet    = empty;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!(in_valid && !in_stall));
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_packet(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(8'($urandom_range(0, 255)), i == 0, i == len - 1, 1'b0);
    end
    packets_sent++;
  endtask

  // hold requests until every byte is out, then write no_ack_mode
  task automatic set_no_ack(input logic v);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned base;
    int unsigned pick;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_no_ack(1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0);
    send_item(8'hA5, 1'b1, 1'b1, 1'b1);
    send_item(8'h5A, 1'b0, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0, 1'b0);
    send_item(8'h7F, 1'b0, 1'b0, 1'b0);
    send_item(8'h2C, 1'b0, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1, 1'b0);
    send_item(8'h10, 1'b0, 1'b0, 1'b0);
    send_item(8'h9B, 1'b0, 1'b1, 1'b0);
    send_item(8'h33, 1'b1, 1'b0, 1'b0);
    send_item(8'h44, 1'b1, 1'b0, 1'b0);
    send_item(8'h01, 1'b0, 1'b1, 1'b0);
    send_item(8'h11, 1'b1, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0, 1'b1);
    send_item(8'h22, 1'b0, 1'b1, 1'b0);
    set_no_ack(1'b1);
    send_item(8'hFE, 1'b1, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1, 1'b1);
    send_item(8'hEE, 1'b1, 1'b0, 1'b0);
    send_item(8'h12, 1'b0, 1'b1, 1'b0);

    base = items_sent;
    for (int unsigned phase = 0; phase < 4; phase++) begin
      set_no_ack(phase[0]);
      calm = (phase == 2);
      while (items_sent < base + PhaseItems * (phase + 1)) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b1);
        end else if (pick == 1) begin
          send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'b0);
        end else if (pick == 2) begin
          send_packet($urandom_range(5, 12));
        end else begin
          send_packet($urandom_range(1, 4));
        end
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d requests (%0d random packets), %0d framed bytes checked",
             items_sent, packets_sent, checked);
    $display("both ack modes, empty and unopened packets, with and without stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dpf_pkg.sv
src/dpf_frame_stage.sv
src/dpf_out_reg.sv
src/debug_packet_framer_unit.sv
bench/dpf_checker.sv
bench/tb_top.sv
